### rtl/core/pdanc_pkg.sv
// Shared types and constants for the PD controller and actuator nonlinearity chain.
package pdanc_pkg;

    localparam int MAP_DEPTH_DEF = 8;
    localparam int SIG_W         = 24;
    localparam int GAIN_W        = 16;
    localparam int CFG_W         = 23;
    localparam int CFG_IDX_W     = 3;
    localparam int PT_IDX_W      = 3;
    localparam int PTS_W         = 4;
    localparam int S_TDATA_W     = 128;
    localparam int M_TDATA_W     = 96;

    localparam int DIV_NUM_W     = 48;
    localparam int DIV_DEN_W     = 24;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd4608;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd1152;
    localparam logic [CFG_W-1:0]  DEAD_ZONE_RST  = 23'd16384;
    localparam logic [CFG_W-1:0]  OUT_LIMIT_RST  = 23'd131072;
    localparam logic [CFG_W-1:0]  BACKLASH_RST   = 23'd13107;
    localparam logic [PTS_W-1:0]  MAP_POINTS_RST = 4'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_DERIV_GAIN = 3'd1,
        REG_DEAD_ZONE  = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_BACKLASH   = 3'd4,
        REG_MAP_ENABLE = 3'd5,
        REG_MAP_POINTS = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_DZ,
        ST_LIM,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_SCAN,
        ST_SEG_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BACKLASH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_p;
        logic mul_d;
        logic sum;
        logic dead_zone;
        logic limit;
        logic latch_last;
        logic latch_prev;
        logic u_from_rd_y;
        logic u_from_last_y;
        logic u_from_prev_y;
        logic latch_seg;
        logic seg_mul;
        logic div_start;
        logic u_from_div;
        logic backlash;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_mode;
        logic map_en;
        logic u_le_first;
        logic u_ge_last;
        logic seg_hit;
        logic seg_flat;
        logic div_done;
    } dp_status_t;

endpackage

### rtl/core/pdanc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pdanc_div #(
    parameter int NUM_W = pdanc_pkg::DIV_NUM_W,
    parameter int DEN_W = pdanc_pkg::DIV_DEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    always_comb begin
        shifted   = {rem_reg, work_reg[NUM_W-1]};
        fits      = (shifted >= {1'b0, den_reg});
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DEN_W'(shifted - {1'b0, den_reg});
            end else begin
                rem_next = shifted[DEN_W-1:0];
            end
            work_next = {work_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

### rtl/core/pdanc_datapath.sv
// Datapath: config registers, PD arithmetic, nonlinearities, map table and output register.
module pdanc_datapath #(
    parameter int MAP_DEPTH = pdanc_pkg::MAP_DEPTH_DEF,
    parameter int AW        = $clog2(MAP_DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pdanc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdanc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                in_mode,
    input  logic signed [pdanc_pkg::SIG_W-1:0]  in_reference,
    input  logic signed [pdanc_pkg::SIG_W-1:0]  in_position,
    input  logic signed [pdanc_pkg::SIG_W-1:0]  in_velocity,
    input  logic [pdanc_pkg::PT_IDX_W-1:0]      in_point_index,
    input  logic signed [pdanc_pkg::SIG_W-1:0]  in_point_x,
    input  logic signed [pdanc_pkg::SIG_W-1:0]  in_point_y,
    input  pdanc_pkg::dp_cmd_t                  cmd,
    input  logic [AW-1:0]                       rd_addr,
    output pdanc_pkg::dp_status_t               status,
    output logic [AW-1:0]                       last_idx,
    output logic signed [pdanc_pkg::SIG_W-1:0]  out_command,
    output logic signed [pdanc_pkg::SIG_W-1:0]  out_after_dead_zone,
    output logic signed [pdanc_pkg::SIG_W-1:0]  out_after_limit,
    output logic signed [pdanc_pkg::SIG_W-1:0]  out_drive,
    output logic                                out_command_clipped
);

    localparam int SW = pdanc_pkg::SIG_W;
    localparam int PW = 42;

    // configuration
    logic [pdanc_pkg::GAIN_W-1:0] prop_gain_reg, deriv_gain_reg;
    logic [pdanc_pkg::CFG_W-1:0]  dz_width_reg, out_limit_reg, bl_width_reg;
    logic                         map_enable_reg;
    logic [pdanc_pkg::PTS_W-1:0]  map_points_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= pdanc_pkg::PROP_GAIN_RST;
            deriv_gain_reg <= pdanc_pkg::DERIV_GAIN_RST;
            dz_width_reg   <= pdanc_pkg::DEAD_ZONE_RST;
            out_limit_reg  <= pdanc_pkg::OUT_LIMIT_RST;
            bl_width_reg   <= pdanc_pkg::BACKLASH_RST;
            map_enable_reg <= 1'b0;
            map_points_reg <= pdanc_pkg::MAP_POINTS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pdanc_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata[pdanc_pkg::GAIN_W-1:0];
                pdanc_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata[pdanc_pkg::GAIN_W-1:0];
                pdanc_pkg::REG_DEAD_ZONE:  dz_width_reg   <= cfg_wdata;
                pdanc_pkg::REG_OUT_LIMIT:  out_limit_reg  <= cfg_wdata;
                pdanc_pkg::REG_BACKLASH:   bl_width_reg   <= cfg_wdata;
                pdanc_pkg::REG_MAP_ENABLE: map_enable_reg <= cfg_wdata[0];
                pdanc_pkg::REG_MAP_POINTS: map_points_reg <= cfg_wdata[pdanc_pkg::PTS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective point count clamped to [2, MAP_DEPTH]
    logic [4:0] n_eff;
    always_comb begin
        if (map_points_reg < pdanc_pkg::PTS_W'(2)) begin
            n_eff = 5'd2;
        end else if ({1'b0, map_points_reg} > 5'(MAP_DEPTH)) begin
            n_eff = 5'(MAP_DEPTH);
        end else begin
            n_eff = {1'b0, map_points_reg};
        end
    end
    assign last_idx = AW'(n_eff - 5'd1);

    // breakpoint tables
    logic signed [SW-1:0] mem_x [MAP_DEPTH];
    logic signed [SW-1:0] mem_y [MAP_DEPTH];
    logic signed [SW-1:0] rd_x_reg, rd_y_reg;
    logic                 pt_wr;

    assign pt_wr = cmd.capture && in_mode && (int'(in_point_index) < MAP_DEPTH);

    always_ff @(posedge aclk) begin
        if (pt_wr) begin
            mem_x[AW'(in_point_index)] <= in_point_x;
            mem_y[AW'(in_point_index)] <= in_point_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // PD command
    logic signed [SW-1:0] ref_reg, pos_reg, vel_reg;
    logic signed [PW-1:0] prod_p_reg, prod_d_reg;
    logic signed [SW:0]   diff_pe;
    logic signed [PW-1:0] prod_p_full, prod_d_full, acc;
    logic signed [PW-9:0] acc_sh;
    logic signed [SW-1:0] cmd_next;
    logic                 clip_next;

    assign diff_pe     = $signed({ref_reg[SW-1], ref_reg}) - $signed({pos_reg[SW-1], pos_reg});
    assign prod_p_full = diff_pe * $signed({1'b0, prop_gain_reg});
    assign prod_d_full = vel_reg * $signed({1'b0, deriv_gain_reg});
    assign acc         = prod_p_reg - prod_d_reg;
    assign acc_sh      = $signed(acc[PW-1:8]);

    always_comb begin
        clip_next = 1'b1;
        if (acc_sh > 34'sd8388607) begin
            cmd_next = 24'sh7FFFFF;
        end else if (acc_sh < -34'sd8388608) begin
            cmd_next = 24'sh800000;
        end else begin
            cmd_next  = acc_sh[SW-1:0];
            clip_next = 1'b0;
        end
    end

    // dead zone and limit
    logic signed [SW-1:0] cmd_reg, dz_reg, lim_reg;
    logic                 clip_reg;
    logic signed [SW:0]   cmd_e, dzw_e, dz_wide, dz_e, lmt_e, lim_wide;

    always_comb begin
        cmd_e = $signed({cmd_reg[SW-1], cmd_reg});
        dzw_e = $signed({2'b00, dz_width_reg});
        if ((cmd_e <= dzw_e) && (cmd_e >= -dzw_e)) begin
            dz_wide = '0;
        end else if (cmd_e > 0) begin
            dz_wide = cmd_e - dzw_e;
        end else begin
            dz_wide = cmd_e + dzw_e;
        end
        dz_e  = $signed({dz_reg[SW-1], dz_reg});
        lmt_e = $signed({2'b00, out_limit_reg});
        if (dz_e > lmt_e) begin
            lim_wide = lmt_e;
        end else if (dz_e < -lmt_e) begin
            lim_wide = -lmt_e;
        end else begin
            lim_wide = dz_e;
        end
    end

    // map evaluation
    logic signed [SW-1:0] last_x_reg, last_y_reg, prev_x_reg, prev_y_reg, y0_reg;
    logic [SW-1:0]        du_reg, den_reg, dy_mag_reg;
    logic                 neg_reg;
    logic [pdanc_pkg::DIV_NUM_W-1:0] num_reg;
    logic signed [SW:0]   du_wide, den_wide, dy_wide, dy_abs;
    logic signed [SW:0]   q_e, q_s, map_wide;
    logic                 div_done;
    logic [pdanc_pkg::DIV_NUM_W-1:0] quot;

    always_comb begin
        du_wide  = $signed({lim_reg[SW-1], lim_reg}) - $signed({prev_x_reg[SW-1], prev_x_reg});
        den_wide = $signed({rd_x_reg[SW-1], rd_x_reg}) - $signed({prev_x_reg[SW-1], prev_x_reg});
        dy_wide  = $signed({rd_y_reg[SW-1], rd_y_reg}) - $signed({prev_y_reg[SW-1], prev_y_reg});
        dy_abs   = dy_wide[SW] ? -dy_wide : dy_wide;
        q_e      = $signed({1'b0, quot[SW-1:0]});
        q_s      = neg_reg ? -q_e : q_e;
        map_wide = $signed({y0_reg[SW-1], y0_reg}) + q_s;
    end

    pdanc_div #(
        .NUM_W(pdanc_pkg::DIV_NUM_W),
        .DEN_W(pdanc_pkg::DIV_DEN_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.div_start),
        .num    (num_reg),
        .den    (den_reg),
        .done   (div_done),
        .quot   (quot)
    );

    // backlash
    logic signed [SW-1:0] u_reg, bl_reg, bl_next;
    logic signed [SW+1:0] u26, y26, h26;

    always_comb begin
        u26     = $signed({{2{u_reg[SW-1]}}, u_reg});
        y26     = $signed({{2{bl_reg[SW-1]}}, bl_reg});
        h26     = $signed({4'b0000, bl_width_reg[pdanc_pkg::CFG_W-1:1]});
        bl_next = bl_reg;
        if (u26 > y26 + h26) begin
            bl_next = SW'(u26 - h26);
        end else if (u26 < y26 - h26) begin
            bl_next = SW'(u26 + h26);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_reg <= '0;
        end else if (cmd.backlash) begin
            bl_reg <= bl_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ref_reg <= in_reference;
            pos_reg <= in_position;
            vel_reg <= in_velocity;
        end
        if (cmd.mul_p) begin
            prod_p_reg <= prod_p_full;
        end
        if (cmd.mul_d) begin
            prod_d_reg <= prod_d_full;
        end
        if (cmd.sum) begin
            cmd_reg  <= cmd_next;
            clip_reg <= clip_next;
        end
        if (cmd.dead_zone) begin
            dz_reg <= dz_wide[SW-1:0];
        end
        if (cmd.limit) begin
            lim_reg <= lim_wide[SW-1:0];
            u_reg   <= lim_wide[SW-1:0];
        end
        if (cmd.latch_last) begin
            last_x_reg <= rd_x_reg;
            last_y_reg <= rd_y_reg;
        end
        if (cmd.latch_prev) begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        if (cmd.u_from_rd_y) begin
            u_reg <= rd_y_reg;
        end
        if (cmd.u_from_last_y) begin
            u_reg <= last_y_reg;
        end
        if (cmd.u_from_prev_y) begin
            u_reg <= prev_y_reg;
        end
        if (cmd.latch_seg) begin
            du_reg     <= du_wide[SW-1:0];
            den_reg    <= den_wide[SW-1:0];
            dy_mag_reg <= dy_abs[SW-1:0];
            neg_reg    <= dy_wide[SW];
            y0_reg     <= prev_y_reg;
        end
        if (cmd.seg_mul) begin
            num_reg <= du_reg * dy_mag_reg;
        end
        if (cmd.u_from_div) begin
            u_reg <= map_wide[SW-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_command         <= cmd_reg;
            out_after_dead_zone <= dz_reg;
            out_after_limit     <= lim_reg;
            out_drive           <= bl_reg;
            out_command_clipped <= clip_reg;
        end
    end

    assign status.in_mode    = in_mode;
    assign status.map_en     = map_enable_reg;
    assign status.u_le_first = (lim_reg <= rd_x_reg);
    assign status.u_ge_last  = (lim_reg >= last_x_reg);
    assign status.seg_hit    = (prev_x_reg <= lim_reg) && (lim_reg <= rd_x_reg);
    assign status.seg_flat   = (rd_x_reg <= prev_x_reg);
    assign status.div_done   = div_done;

endmodule

### rtl/core/pdanc_ctrl.sv
// Controller: sequences PD arithmetic, map search, divider and output handshake.
module pdanc_ctrl #(
    parameter int MAP_DEPTH = pdanc_pkg::MAP_DEPTH_DEF,
    parameter int AW        = $clog2(MAP_DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  pdanc_pkg::dp_status_t status,
    input  logic [AW-1:0]         last_idx,
    output pdanc_pkg::dp_cmd_t    cmd,
    output logic [AW-1:0]         rd_addr
);

    pdanc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]     k_reg, k_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pdanc_pkg::ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        rd_addr      = '0;
        s_tready     = 1'b0;
        case (state_reg)
            pdanc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (!status.in_mode) begin
                        state_next = pdanc_pkg::ST_MUL_P;
                    end
                end
            end
            pdanc_pkg::ST_MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = pdanc_pkg::ST_MUL_D;
            end
            pdanc_pkg::ST_MUL_D: begin
                cmd.mul_d  = 1'b1;
                state_next = pdanc_pkg::ST_SUM;
            end
            pdanc_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = pdanc_pkg::ST_DZ;
            end
            pdanc_pkg::ST_DZ: begin
                cmd.dead_zone = 1'b1;
                state_next    = pdanc_pkg::ST_LIM;
            end
            pdanc_pkg::ST_LIM: begin
                cmd.limit  = 1'b1;
                state_next = status.map_en ? pdanc_pkg::ST_RD_LAST : pdanc_pkg::ST_BACKLASH;
            end
            pdanc_pkg::ST_RD_LAST: begin
                rd_addr    = last_idx;
                state_next = pdanc_pkg::ST_RD_FIRST;
            end
            pdanc_pkg::ST_RD_FIRST: begin
                rd_addr        = '0;
                cmd.latch_last = 1'b1;
                state_next     = pdanc_pkg::ST_CHK_FIRST;
            end
            pdanc_pkg::ST_CHK_FIRST: begin
                cmd.latch_prev = 1'b1;
                if (status.u_le_first) begin
                    cmd.u_from_rd_y = 1'b1;
                    state_next      = pdanc_pkg::ST_BACKLASH;
                end else if (status.u_ge_last) begin
                    cmd.u_from_last_y = 1'b1;
                    state_next        = pdanc_pkg::ST_BACKLASH;
                end else begin
                    rd_addr    = AW'(1);
                    k_next     = AW'(1);
                    state_next = pdanc_pkg::ST_SCAN;
                end
            end
            pdanc_pkg::ST_SCAN: begin
                if (status.seg_hit) begin
                    if (status.seg_flat) begin
                        cmd.u_from_prev_y = 1'b1;
                        state_next        = pdanc_pkg::ST_BACKLASH;
                    end else begin
                        cmd.latch_seg = 1'b1;
                        state_next    = pdanc_pkg::ST_SEG_MUL;
                    end
                end else if (k_reg == last_idx) begin
                    cmd.u_from_last_y = 1'b1;
                    state_next        = pdanc_pkg::ST_BACKLASH;
                end else begin
                    cmd.latch_prev = 1'b1;
                    rd_addr        = k_reg + AW'(1);
                    k_next         = k_reg + AW'(1);
                end
            end
            pdanc_pkg::ST_SEG_MUL: begin
                cmd.seg_mul = 1'b1;
                state_next  = pdanc_pkg::ST_DIV_START;
            end
            pdanc_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = pdanc_pkg::ST_DIV_WAIT;
            end
            pdanc_pkg::ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.u_from_div = 1'b1;
                    state_next     = pdanc_pkg::ST_BACKLASH;
                end
            end
            pdanc_pkg::ST_BACKLASH: begin
                cmd.backlash = 1'b1;
                state_next   = pdanc_pkg::ST_OUT;
            end
            pdanc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pdanc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdanc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

### rtl/core/pd_actuator_nonlinearity_chain_top.sv
// Top level: PD controller with dead zone, limit, piecewise-linear map and backlash.
// Load beat: accepted in the idle state, no result. Control beat without map: result follows
// the multiply, sum, dead zone, limit and backlash states. With map: table reads, a scan of up to
// MAP_DEPTH-1 segments over the table port and the 48-step divider also lie in its path.
// One beat in flight; the output register lets the next beat enter while a result waits.
// Reset: config registers to defaults, backlash output cleared; map tables not cleared.
module pd_actuator_nonlinearity_chain_top #(
    parameter int MAP_DEPTH = pdanc_pkg::MAP_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pdanc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdanc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // reference, position, velocity, point_index, point_x, point_y, zero pad
    input  logic [pdanc_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // command, after_dead_zone, after_limit, drive
    output logic [pdanc_pkg::M_TDATA_W-1:0]     m_tdata,
    // command_clipped
    output logic                                m_tuser
);

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int SW = pdanc_pkg::SIG_W;

    pdanc_pkg::dp_cmd_t    cmd;
    pdanc_pkg::dp_status_t status;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         last_idx;
    logic signed [SW-1:0]  o_command, o_dz, o_lim, o_drive;
    logic                  o_clipped;

    pdanc_ctrl #(
        .MAP_DEPTH(MAP_DEPTH),
        .AW       (AW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .last_idx(last_idx),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    pdanc_datapath #(
        .MAP_DEPTH(MAP_DEPTH),
        .AW       (AW)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .in_mode            (s_tuser),
        .in_reference       ($signed(s_tdata[23:0])),
        .in_position        ($signed(s_tdata[47:24])),
        .in_velocity        ($signed(s_tdata[71:48])),
        .in_point_index     (s_tdata[74:72]),
        .in_point_x         ($signed(s_tdata[98:75])),
        .in_point_y         ($signed(s_tdata[122:99])),
        .cmd                (cmd),
        .rd_addr            (rd_addr),
        .status             (status),
        .last_idx           (last_idx),
        .out_command        (o_command),
        .out_after_dead_zone(o_dz),
        .out_after_limit    (o_lim),
        .out_drive          (o_drive),
        .out_command_clipped(o_clipped)
    );

    assign m_tdata = {o_drive, o_lim, o_dz, o_command};
    assign m_tuser = o_clipped;

endmodule

### sim/pd_actuator_nonlinearity_chain_top_test.sv
// Testbench for the PD controller and actuator nonlinearity chain: stream stimulus and scoreboard.
module pd_actuator_nonlinearity_chain_top_test;
    import pdanc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_BEATS  = 140;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic MODE_CTRL = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam int TAB_X [8] = '{-6000000, -3000000, -1000000, -200000,
                                 0, 400000, 2000000, 6000000};
    localparam int TAB_Y [8] = '{8388607, -8388608, 1234567, -500000,
                                 0, 3000000, -7000000, 8388607};

    typedef struct {
        logic [SIG_W-1:0] command;
        logic [SIG_W-1:0] dead;
        logic [SIG_W-1:0] limited;
        logic [SIG_W-1:0] drive;
        logic             clipped;
    } chain_out_t;

    class pd_chain_scoreboard;
        logic [GAIN_W-1:0] kp, kd;
        logic [CFG_W-1:0]  dz_w, lim_w, bl_w;
        logic              map_en;
        logic [PTS_W-1:0]  n_pts;
        longint            bl_out;
        longint            tab_x [MAP_DEPTH_DEF];
        longint            tab_y [MAP_DEPTH_DEF];
        chain_out_t        expq [$];
        int                errors;

        function new();
            kp     = PROP_GAIN_RST;
            kd     = DERIV_GAIN_RST;
            dz_w   = DEAD_ZONE_RST;
            lim_w  = OUT_LIMIT_RST;
            bl_w   = BACKLASH_RST;
            map_en = 1'b0;
            n_pts  = MAP_POINTS_RST;
            bl_out = 0;
            errors = 0;
            for (int i = 0; i < MAP_DEPTH_DEF; i++) begin
                tab_x[i] = 0;
                tab_y[i] = 0;
            end
        endfunction

        function int pending();
            return expq.size();
        endfunction

        function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_PROP_GAIN:  kp = val[GAIN_W-1:0];
                REG_DERIV_GAIN: kd = val[GAIN_W-1:0];
                REG_DEAD_ZONE:  dz_w = val;
                REG_OUT_LIMIT:  lim_w = val;
                REG_BACKLASH:   bl_w = val;
                REG_MAP_ENABLE: map_en = val[0];
                REG_MAP_POINTS: n_pts = val[PTS_W-1:0];
                default: ;
            endcase
        endfunction

        function longint lookup(longint u);
            int     n;
            longint x0, x1, y0, y1;
            n = n_pts;
            if (n < 2) n = 2;
            if (n > MAP_DEPTH_DEF) n = MAP_DEPTH_DEF;
            if (u <= tab_x[0]) return tab_y[0];
            if (u >= tab_x[n-1]) return tab_y[n-1];
            for (int i = 0; i + 1 < n; i++) begin
                x0 = tab_x[i];
                x1 = tab_x[i+1];
                if (x0 <= u && u <= x1) begin
                    y0 = tab_y[i];
                    y1 = tab_y[i+1];
                    if (x1 - x0 <= 0) return y0;
                    return y0 + ((u - x0) * (y1 - y0)) / (x1 - x0);
                end
            end
            return tab_y[n-1];
        endfunction

        function void note_beat(logic [S_TDATA_W-1:0] data, logic mode);
            longint     r, p, v, acc, cmd, d, m, dz, lim, u, half, kpl, kdl;
            logic       clip;
            chain_out_t e;
            if (mode == MODE_LOAD) begin
                tab_x[data[74:72]] = $signed(data[98:75]);
                tab_y[data[74:72]] = $signed(data[122:99]);
                return;
            end
            r    = $signed(data[23:0]);
            p    = $signed(data[47:24]);
            v    = $signed(data[71:48]);
            kpl  = kp;
            kdl  = kd;
            acc  = kpl * (r - p) - kdl * v;
            cmd  = acc >>> 8;
            clip = 1'b0;
            if (cmd > 64'sd8388607) begin
                cmd  = 8388607;
                clip = 1'b1;
            end
            if (cmd < -64'sd8388608) begin
                cmd  = -8388608;
                clip = 1'b1;
            end
            d = dz_w;
            if (cmd <= d && cmd >= -d) dz = 0;
            else if (cmd > 0) dz = cmd - d;
            else dz = cmd + d;
            m   = lim_w;
            lim = dz;
            if (lim > m) lim = m;
            if (lim < -m) lim = -m;
            u    = map_en ? lookup(lim) : lim;
            half = bl_w >> 1;
            if (u > bl_out + half) bl_out = u - half;
            else if (u < bl_out - half) bl_out = u + half;
            e.command = 24'(cmd);
            e.dead    = 24'(dz);
            e.limited = 24'(lim);
            e.drive   = 24'(bl_out);
            e.clipped = clip;
            expq.push_back(e);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_beat(logic [M_TDATA_W-1:0] data, logic clip);
            chain_out_t e;
            if (expq.size() == 0) begin
                report($sformatf("result beat %h with nothing expected", data));
                return;
            end
            e = expq.pop_front();
            if (data[23:0] != e.command)
                report($sformatf("command %h, want %h", data[23:0], e.command));
            if (data[47:24] != e.dead)
                report($sformatf("after_dead_zone %h, want %h", data[47:24], e.dead));
            if (data[71:48] != e.limited)
                report($sformatf("after_limit %h, want %h", data[71:48], e.limited));
            if (data[95:72] != e.drive)
                report($sformatf("drive %h, want %h", data[95:72], e.drive));
            if (clip != e.clipped)
                report($sformatf("command_clipped %b, want %b", clip, e.clipped));
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    bit                 gaps_on   = 1'b1;
    int                 stall_cnt = 0;
    pd_chain_scoreboard sb = new();

    pd_actuator_nonlinearity_chain_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= !(gaps_on && $urandom_range(99) < 31);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.write_cfg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) sb.note_beat(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
            if (cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("pd_actuator_nonlinearity_chain_top: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [SIG_W-1:0] rand_sig();
        logic signed [31:0] t;
        t = $urandom;
        t = t >>> $urandom_range(8, 31);
        return t[23:0];
    endfunction

    function automatic logic [CFG_W-1:0] rand_mag();
        case ($urandom_range(3))
            0: return '0;
            1: return 23'h7FFFFF;
            2: return 23'($urandom);
            default: return 23'($urandom >> $urandom_range(9, 31));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(3))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 2048));
        endcase
    endfunction

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task send_beat(input logic mode, input logic [SIG_W-1:0] r, p, v,
                   input logic [PT_IDX_W-1:0] idx, input logic [SIG_W-1:0] px, py);
        while (gaps_on && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'd0, py, px, idx, v, p, r};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task unity_setup(input logic [CFG_W-1:0] gap, input logic map_on);
        write_reg(REG_PROP_GAIN, 23'd256);
        write_reg(REG_DERIV_GAIN, 23'd0);
        write_reg(REG_DEAD_ZONE, 23'd0);
        write_reg(REG_OUT_LIMIT, 23'h7FFFFF);
        write_reg(REG_BACKLASH, gap);
        write_reg(REG_MAP_ENABLE, 23'(map_on));
        write_reg(REG_MAP_POINTS, 23'd8);
    endtask

    task random_phase(input int phase, input int count);
        int               xs [$];
        logic [SIG_W-1:0] px;
        logic             map_on;
        settle();
        gaps_on = (phase != 4);
        map_on  = (phase < 2) || phase[0];
        if (phase == 0) begin
            write_reg(REG_PROP_GAIN, 23'hFFFF);
            write_reg(REG_DERIV_GAIN, 23'hFFFF);
            write_reg(REG_DEAD_ZONE, 23'h7FFFFF);
            write_reg(REG_OUT_LIMIT, 23'h7FFFFF);
            write_reg(REG_BACKLASH, 23'h7FFFFF);
            write_reg(REG_MAP_POINTS, 23'd15);
        end else if (phase == 1) begin
            write_reg(REG_PROP_GAIN, 23'd0);
            write_reg(REG_DERIV_GAIN, 23'd0);
            write_reg(REG_DEAD_ZONE, 23'd0);
            write_reg(REG_OUT_LIMIT, 23'd0);
            write_reg(REG_BACKLASH, 23'd0);
            write_reg(REG_MAP_POINTS, 23'd0);
        end else begin
            write_reg(REG_PROP_GAIN, 23'(rand_gain()));
            write_reg(REG_DERIV_GAIN, 23'(rand_gain()));
            write_reg(REG_DEAD_ZONE, rand_mag());
            write_reg(REG_OUT_LIMIT, rand_mag());
            write_reg(REG_BACKLASH, rand_mag());
            write_reg(REG_MAP_POINTS, 23'($urandom_range(0, 15)));
        end
        write_reg(REG_MAP_ENABLE, 23'(map_on));
        if (map_on) begin
            // fresh ascending table so interpolation sees sane segments
            for (int i = 0; i < MAP_DEPTH_DEF; i++) xs.push_back(int'($signed(rand_sig())));
            xs.sort();
            for (int i = 0; i < MAP_DEPTH_DEF; i++) begin
                px = xs[i];
                send_beat(MODE_LOAD, rand_sig(), rand_sig(), rand_sig(), 3'(i), px, rand_sig());
            end
        end
        repeat (count) begin
            if ($urandom_range(99) < 8)
                send_beat(MODE_LOAD, rand_sig(), rand_sig(), rand_sig(),
                          3'($urandom), rand_sig(), rand_sig());
            else
                send_beat(MODE_CTRL, rand_sig(), rand_sig(), rand_sig(),
                          3'($urandom), rand_sig(), rand_sig());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: clipping both ways, zero, small commands around the dead zone
        send_beat(MODE_CTRL, 24'h7FFFFF, 24'h800000, 24'h800000, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, 24'd0, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, 24'd1000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, -24'sd1000, 24'd0, 24'd500, 3'd0, 24'd0, 24'd0);
        for (int i = 0; i < MAP_DEPTH_DEF; i++)
            send_beat(MODE_LOAD, 24'd0, 24'd0, 24'd0, 3'(i), 24'(TAB_X[i]), 24'(TAB_Y[i]));

        // map on, unity gain: clamp low, clamp high, interpolation
        settle();
        unity_setup(23'd0, 1'b1);
        send_beat(MODE_CTRL, -24'sd7000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, 24'd7000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, 24'd100000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, -24'sd2500000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);

        // point count below 2 and above the table depth
        settle();
        write_reg(REG_MAP_POINTS, 23'd0);
        send_beat(MODE_CTRL, -24'sd4000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        settle();
        write_reg(REG_MAP_POINTS, 23'd15);
        send_beat(MODE_CTRL, 24'd5000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);

        // repeated abscissa
        send_beat(MODE_LOAD, 24'd0, 24'd0, 24'd0, 3'd3, 24'(TAB_X[2]), 24'd777);
        send_beat(MODE_CTRL, 24'(TAB_X[2]), 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);

        // widest backlash gap: move up, hold inside the gap, move down
        settle();
        unity_setup(23'h7FFFFF, 1'b0);
        write_reg(REG_NONE, 23'h7FFFFF);
        send_beat(MODE_CTRL, 24'd8000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, 24'd5000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);
        send_beat(MODE_CTRL, -24'sd8000000, 24'd0, 24'd0, 3'd0, 24'd0, 24'd0);

        for (int ph = 0; ph < RAND_PHASES; ph++) random_phase(ph, PHASE_BEATS);

        gaps_on = 1'b1;
        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("pd_actuator_nonlinearity_chain_top: match");
        else
            $display("pd_actuator_nonlinearity_chain_top: mismatch");
        $finish;
    end

endmodule
